// ===== src/hlfd_pkg.sv =====
// shared types and constants of the multi-bit huffman lookahead decoder
// no dependencies; imported by every module of the block except hlfd_ram
package hlfd_pkg;

  localparam int LOOKAHEAD_BITS_DEF    = 4;
  localparam int MAX_STATES_DEF        = 512;
  localparam int SYMBOLS_PER_ENTRY_DEF = 4;

  localparam int IDX_W           = 13;
  localparam int STATE_FIELD_W   = 9;
  localparam int CNT_W           = 3;
  localparam int SYMS_W          = 32;
  localparam int SYM_W           = 8;
  localparam int WIN_W           = 4;
  localparam int WIN_MAX_W       = 8;
  localparam int COUNT_W         = 24;
  localparam int MAX_SYMS_PACKED = 4;
  localparam int QUEUE_DEPTH     = 4;
  localparam int IN_DATA_W       = 64;
  localparam int IN_USER_W       = 2;
  localparam int OUT_DATA_W      = 16;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_DECODE  = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  // table entry, next state in the low bits
  typedef struct packed {
    logic [SYMS_W-1:0]        syms;
    logic [CNT_W-1:0]         cnt;
    logic [CNT_W-1:0]         used;
    logic [STATE_FIELD_W-1:0] next;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // classified command handed from front to back
  typedef struct packed {
    op_t                  op;
    logic [IDX_W-1:0]     idx;
    logic [IDX_W-1:0]     quot;
    entry_t               entry;
    logic [WIN_MAX_W-1:0] win;
  } cmd_t;

  // result job handed from back to the output stage
  typedef struct packed {
    logic [SYMS_W-1:0] syms;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  used;
    logic              done_end;
  } job_t;

endpackage

// ===== src/hlfd_ram.sv =====
// generic simple dual-port ram with registered read
// no dependencies
module hlfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/hlfd_front.sv =====
// input side: accepts stream transactions, classifies the operation and
// starts the table index reduction; uses hlfd_pkg
module hlfd_front import hlfd_pkg::*; #(
  parameter int LOOKAHEAD_BITS = LOOKAHEAD_BITS_DEF,
  parameter int TABLE_DEPTH    = MAX_STATES_DEF << LOOKAHEAD_BITS_DEF
) (
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [IN_USER_W-1:0] in_tuser,
  input  logic                 q_full,
  output logic                 q_push,
  output cmd_t                 q_cmd
);

  // quotient idx / TABLE_DEPTH by reciprocal, exact for all 13-bit indexes
  localparam int              L2D     = $clog2(TABLE_DEPTH);
  localparam int              SHIFT   = IDX_W + L2D;
  localparam longint unsigned RECIP   = ((64'd1 << SHIFT) + TABLE_DEPTH - 1) / TABLE_DEPTH;
  localparam int              RECIP_W = $clog2(RECIP + 1);
  localparam int              PROD_W  = IDX_W + RECIP_W;
  localparam logic [WIN_MAX_W-1:0] WIN_MASK = WIN_MAX_W'((1 << LOOKAHEAD_BITS) - 1);

  logic             keep;
  logic [IDX_W-1:0] idx;
  logic [PROD_W-1:0] prod;

  assign idx  = in_tdata[12:0];
  assign prod = PROD_W'(idx) * PROD_W'(RECIP);

  always_comb begin
    unique case (in_tuser)
      OP_WRITE, OP_DECODE, OP_RESTART: keep = 1'b1;
      default:                         keep = 1'b0;  // unused code is dropped
    endcase
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full && keep;

  always_comb begin
    q_cmd            = '0;
    q_cmd.op         = op_t'(in_tuser);
    q_cmd.idx        = idx;
    q_cmd.quot       = IDX_W'(prod >> SHIFT);
    q_cmd.entry.next = in_tdata[21:13];
    q_cmd.entry.used = in_tdata[24:22];
    q_cmd.entry.cnt  = in_tdata[27:25];
    q_cmd.entry.syms = in_tdata[59:28];
    q_cmd.win        = WIN_MAX_W'(in_tdata[63:60]) & WIN_MASK;
  end

endmodule

// ===== src/hlfd_queue.sv =====
// small command queue between front and back
// uses hlfd_pkg for the command type and depth
module hlfd_queue import hlfd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic head_valid,
  output cmd_t head_cmd,
  input  logic pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;

  assign full       = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

// ===== src/hlfd_emit.sv =====
// output stage: unpacks one job into result transactions, one symbol each
// uses hlfd_pkg for the job type
module hlfd_emit import hlfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_valid,
  input  job_t                  job,
  output logic                  job_ready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // symbol, bits_consumed, done_res
  output logic [0:0]            out_tuser,   // symbol_valid
  output logic                  out_tlast
);

  logic              em_valid_r, em_valid_nxt;
  logic [SYMS_W-1:0] em_syms_r, em_syms_nxt;
  logic [CNT_W-1:0]  em_left_r, em_left_nxt;
  logic [CNT_W-1:0]  em_used_r, em_used_nxt;
  logic              em_done_r, em_done_nxt;
  logic              em_last;
  logic              has_sym;

  // a job with no symbols still gives one result
  assign em_last   = (em_left_r <= CNT_W'(1));
  assign has_sym   = (em_left_r != '0);
  assign job_ready = !em_valid_r || (out_tready && em_last);

  always_comb begin
    em_valid_nxt = em_valid_r;
    em_syms_nxt  = em_syms_r;
    em_left_nxt  = em_left_r;
    em_used_nxt  = em_used_r;
    em_done_nxt  = em_done_r;
    if (em_valid_r && out_tready && !em_last) begin
      em_left_nxt = em_left_r - 1'b1;
      em_syms_nxt = em_syms_r >> SYM_W;
    end
    if (job_valid && job_ready) begin
      em_valid_nxt = 1'b1;
      em_syms_nxt  = job.syms;
      em_left_nxt  = job.count;
      em_used_nxt  = job.used;
      em_done_nxt  = job.done_end;
    end else if (em_valid_r && out_tready && em_last) begin
      em_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_valid_r <= 1'b0;
    end else begin
      em_valid_r <= em_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    em_syms_r <= em_syms_nxt;
    em_left_r <= em_left_nxt;
    em_used_r <= em_used_nxt;
    em_done_r <= em_done_nxt;
  end

  assign out_tvalid   = em_valid_r;
  assign out_tlast    = em_last;
  assign out_tuser[0] = has_sym;
  assign out_tdata    = {4'b0000, em_last && em_done_r, em_used_r,
                         has_sym ? em_syms_r[SYM_W-1:0] : {SYM_W{1'b0}}};

  emit_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    em_valid_r |-> (em_left_r <= CNT_W'(MAX_SYMS_PACKED)))
    else $error("output stage holds too many symbols");

endmodule

// ===== src/hlfd_back.sv =====
// back end: table writes, restart and the table lookup (registered memory read,
// then apply the entry) with the state and emitted-count registers; uses hlfd_pkg and hlfd_ram
module hlfd_back import hlfd_pkg::*; #(
  parameter int LOOKAHEAD_BITS    = LOOKAHEAD_BITS_DEF,
  parameter int MAX_STATES        = MAX_STATES_DEF,
  parameter int SYMBOLS_PER_ENTRY = SYMBOLS_PER_ENTRY_DEF,
  parameter int TABLE_DEPTH       = MAX_STATES_DEF << LOOKAHEAD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  input  logic               head_valid,
  input  cmd_t               head_cmd,
  output logic               pop,
  output logic               job_valid,
  output job_t               job,
  input  logic               job_ready
);

  localparam int SW = $clog2(MAX_STATES);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] USED_MAX =
    CNT_W'((LOOKAHEAD_BITS < 7) ? LOOKAHEAD_BITS : 7);
  localparam logic [CNT_W-1:0] CNT_MAX =
    CNT_W'((SYMBOLS_PER_ENTRY < MAX_SYMS_PACKED) ? SYMBOLS_PER_ENTRY : MAX_SYMS_PACKED);

  logic [COUNT_W-1:0] msg_r, msg_nxt;
  logic [COUNT_W-1:0] emitted_r, emitted_nxt;
  logic [SW-1:0]      cur_state_r, cur_state_nxt;
  logic               b_valid_r, b_valid_nxt;

  logic               a_write, a_restart, a_dec, msg_done, a_done_go, rd_issue, b_retire;
  logic [IDX_W-1:0]   qd, rem;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  entry_t             e;
  logic [CNT_W-1:0]   used_c, cnt_c, n;
  logic [COUNT_W-1:0] remain;
  logic               cnt_ge;
  logic [SW-1:0]      next_ok;
  job_t               b_job, done_job;

  // index modulo table depth, quotient came from the front
  assign qd      = IDX_W'(32'(head_cmd.quot) * 32'(TABLE_DEPTH));
  assign rem     = head_cmd.idx - qd;
  assign wr_addr = AW'(rem);
  assign rd_addr = {cur_state_r, head_cmd.win[LOOKAHEAD_BITS-1:0]};

  hlfd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (a_write),
    .wr_addr (wr_addr),
    .wr_data (head_cmd.entry),
    .rd_en   (rd_issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // decodes and restarts wait for the lookup in flight to retire
  assign msg_done  = (emitted_r >= msg_r);
  assign a_write   = head_valid && (head_cmd.op == OP_WRITE);
  assign a_restart = head_valid && (head_cmd.op == OP_RESTART) && !b_valid_r;
  assign a_dec     = head_valid && (head_cmd.op == OP_DECODE) && !b_valid_r;
  assign a_done_go = a_dec && msg_done && job_ready;
  assign rd_issue  = a_dec && !msg_done;
  assign b_retire  = b_valid_r && job_ready;
  assign pop       = a_write || a_restart || a_done_go || rd_issue;

  assign e       = entry_t'(rd_data);
  assign used_c  = (e.used > USED_MAX) ? USED_MAX : e.used;
  assign cnt_c   = (e.cnt > CNT_MAX) ? CNT_MAX : e.cnt;
  assign remain  = msg_r - emitted_r;
  assign cnt_ge  = (COUNT_W'(cnt_c) >= remain);
  // message ends inside this entry: only the remaining symbols go out
  assign n       = cnt_ge ? remain[CNT_W-1:0] : cnt_c;
  assign next_ok = ({1'b0, e.next} < (STATE_FIELD_W+1)'(MAX_STATES)) ? SW'(e.next) : '0;

  always_comb begin
    b_job          = '0;
    b_job.syms     = e.syms;
    b_job.count    = n;
    b_job.used     = used_c;
    b_job.done_end = cnt_ge;
    done_job          = '0;
    done_job.done_end = 1'b1;
  end

  assign job_valid = b_valid_r || (a_dec && msg_done);
  assign job       = b_valid_r ? b_job : done_job;

  always_comb begin
    msg_nxt       = msg_r;
    emitted_nxt   = emitted_r;
    cur_state_nxt = cur_state_r;
    b_valid_nxt   = b_valid_r;
    if (cfg_wr_en) begin
      msg_nxt = cfg_wr_data;
    end
    if (rd_issue) begin
      b_valid_nxt = 1'b1;
    end else if (b_retire) begin
      b_valid_nxt = 1'b0;
    end
    if (a_restart) begin
      emitted_nxt   = '0;
      cur_state_nxt = '0;
    end else if (b_retire) begin
      emitted_nxt   = emitted_r + COUNT_W'(n);
      cur_state_nxt = next_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_r       <= '0;
      emitted_r   <= '0;
      cur_state_r <= '0;
      b_valid_r   <= 1'b0;
    end else begin
      msg_r       <= msg_nxt;
      emitted_r   <= emitted_nxt;
      cur_state_r <= cur_state_nxt;
      b_valid_r   <= b_valid_nxt;
    end
  end

  lookup_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    rd_issue |=> b_valid_r)
    else $error("table read issued without lookup stage");

  lookup_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !job_ready) |=> (b_valid_r && $stable(cur_state_r) && $stable(emitted_r)))
    else $error("stalled lookup lost or state moved");

  restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    a_restart |=> ((cur_state_r == '0) && (emitted_r == '0)))
    else $error("restart did not clear state and count");

endmodule

// ===== src/huffman_lookahead_fsm_decoder.sv =====
// top level of the table-driven multi-bit huffman decoder
// depends on hlfd_pkg, hlfd_front, hlfd_queue, hlfd_back, hlfd_emit
//
// Operation in in_tuser: table write, decode window or restart; code 3 is
// accepted and dropped. A decode in the back end first reads the table
// memory and then applies the entry, and the next decode or restart waits
// for the state it leaves, so a decode is not taken before the last one
// is through. Each decode gives one to four results, one per cycle at the
// output register while out_tready is high. A four-entry command queue
// between the input and the back end lets the input keep accepting while
// results are still being taken.
module huffman_lookahead_fsm_decoder import hlfd_pkg::*; #(
  parameter int LOOKAHEAD_BITS    = LOOKAHEAD_BITS_DEF,
  parameter int MAX_STATES        = MAX_STATES_DEF,
  parameter int SYMBOLS_PER_ENTRY = SYMBOLS_PER_ENTRY_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [COUNT_W-1:0]    cfg_wr_data,  // message_symbol_count
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // entry_index, entry_next_state, entry_bits_consumed, entry_symbol_count,
  // entry_symbols, window_bits
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,     // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,    // symbol, bits_consumed, done_res
  output logic [0:0]            out_tuser,    // symbol_valid
  output logic                  out_tlast     // last
);

  localparam int TABLE_DEPTH = MAX_STATES << LOOKAHEAD_BITS;

  logic q_full, q_push, head_valid, pop, job_valid, job_ready;
  cmd_t q_cmd, head_cmd;
  job_t job;

  hlfd_front #(
    .LOOKAHEAD_BITS (LOOKAHEAD_BITS),
    .TABLE_DEPTH    (TABLE_DEPTH)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  hlfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  hlfd_back #(
    .LOOKAHEAD_BITS    (LOOKAHEAD_BITS),
    .MAX_STATES        (MAX_STATES),
    .SYMBOLS_PER_ENTRY (SYMBOLS_PER_ENTRY),
    .TABLE_DEPTH       (TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .job_valid   (job_valid),
    .job         (job),
    .job_ready   (job_ready)
  );

  hlfd_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_valid),
    .job        (job),
    .job_ready  (job_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== verif/huffman_lookahead_fsm_decoder_tb.sv =====
// self-checking testbench for the multi-bit huffman lookahead decoder
// depends on hlfd_pkg and huffman_lookahead_fsm_decoder; checks every output transaction
// against a table-walking predictor, directed rows first, then random phases
module huffman_lookahead_fsm_decoder_tb;
  import hlfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS = 78;

  typedef struct packed {
    logic [1:0]  op;
    logic [12:0] idx;
    logic [8:0]  nxt;
    logic [2:0]  used;
    logic [2:0]  cnt;
    logic [31:0] syms;
    logic [3:0]  win;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       valid;
    logic       last;
    logic [2:0] used;
    logic       done;
  } sym_res_t;

  typedef struct packed {
    logic        is_cfg;
    logic [23:0] cfg_val;
    cmd_item_t   cmd;
    logic        typed;
    sym_res_t    res;
  } dir_row_t;

  localparam sym_res_t DONE_RES = '{sym: 8'd0, valid: 1'b0, last: 1'b1, used: 3'd0,
                                    done: 1'b1};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0]    cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  out_tlast;

  huffman_lookahead_fsm_decoder uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // entry_index, entry_next_state, entry_bits_consumed,
                                // entry_symbol_count, entry_symbols, window_bits
    .in_tuser    (in_tuser),    // operation
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),   // symbol, bits_consumed, done_res
    .out_tuser   (out_tuser),   // symbol_valid
    .out_tlast   (out_tlast)    // last
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // decoder model state
  entry_t      tab_mem [0:8191];
  bit          tab_written [0:8191];
  logic [8:0]  dec_state = '0;
  logic [23:0] emitted = '0;
  logic [23:0] msg_len = '0;
  bit          live [0:511];
  int          live_states[$];
  sym_res_t    step_res [0:3];

  sym_res_t    sym_fifo[$];
  dir_row_t    dir_tab[$];
  int          fail_cnt = 0;
  int          burst_left = 0;

  // receiver stall pattern
  int          rdy_mode = 0;
  int          rdy_cnt = 0;
  logic [31:0] rdy_pat = '1;

  // walks one command through the table, fills step_res, returns result count
  function automatic int predict(input cmd_item_t c);
    entry_t      e;
    logic [2:0]  used;
    logic [2:0]  cnt;
    logic [23:0] remain;
    int          n;
    case (c.op)
      OP_WRITE: begin
        tab_mem[c.idx] = {c.syms, c.cnt, c.used, c.nxt};
        tab_written[c.idx] = 1'b1;
        if (!live[c.idx[12:4]]) begin
          live[c.idx[12:4]] = 1'b1;
          live_states.push_back(int'(c.idx[12:4]));
        end
        return 0;
      end
      OP_RESTART: begin
        dec_state = '0;
        emitted = '0;
        return 0;
      end
      OP_DECODE: begin
        if (emitted >= msg_len) begin
          step_res[0] = DONE_RES;
          return 1;
        end
        e = tab_mem[{dec_state, c.win}];
        used = (e.used > 3'd4) ? 3'd4 : e.used;
        cnt = (e.cnt > 3'd4) ? 3'd4 : e.cnt;
        remain = msg_len - emitted;
        n = (remain < cnt) ? int'(remain) : int'(cnt);
        dec_state = e.next;
        if (n == 0) begin
          step_res[0] = '{sym: 8'd0, valid: 1'b0, last: 1'b1, used: used,
                          done: (emitted >= msg_len)};
          return 1;
        end
        for (int k = 0; k < n; k++) begin
          emitted = emitted + 24'd1;
          step_res[k] = '{sym: e.syms[8*k +: 8], valid: 1'b1, last: (k == n - 1),
                          used: used, done: (emitted >= msg_len)};
        end
        return n;
      end
      default: return 0;
    endcase
  endfunction

  function automatic void dir_cmd(input logic [1:0] op, input logic [12:0] idx,
                                  input logic [8:0] nxt, input logic [2:0] used,
                                  input logic [2:0] cnt, input logic [31:0] syms,
                                  input logic [3:0] win);
    dir_row_t r;
    r = '0;
    r.cmd = '{op: op, idx: idx, nxt: nxt, used: used, cnt: cnt, syms: syms, win: win};
    dir_tab.push_back(r);
  endfunction

  // decode with the message already complete
  function automatic void dir_done(input logic [3:0] win);
    dir_row_t r;
    r = '0;
    r.cmd.op = OP_DECODE;
    r.cmd.win = win;
    r.typed = 1'b1;
    r.res = DONE_RES;
    dir_tab.push_back(r);
  endfunction

  function automatic void dir_cfg(input logic [23:0] val);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.cfg_val = val;
    dir_tab.push_back(r);
  endfunction

  // random command; decodes only use windows already written for the current state
  function automatic cmd_item_t gen_item();
    cmd_item_t  c;
    logic [3:0] opts[$];
    logic [8:0] st;
    int         r;
    {c.idx, c.nxt, c.used, c.cnt, c.syms, c.win} = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 4) begin
      c.op = OP_UNUSED;
    end else if (r < 24) begin
      c.op = OP_WRITE;
      case ($urandom_range(0, 3))
        0: st = 9'($urandom_range(0, 511));
        1: st = dec_state;
        default: st = 9'(live_states[$urandom_range(0, live_states.size() - 1)]);
      endcase
      c.idx = {st, c.win};
      if ($urandom_range(0, 4) == 0) c.nxt = st;
      else c.nxt = 9'(live_states[$urandom_range(0, live_states.size() - 1)]);
    end else if (r < 30 || (emitted >= msg_len && r < 65)) begin
      c.op = OP_RESTART;
    end else begin
      c.op = OP_DECODE;
      for (int w = 0; w < 16; w++)
        if (tab_written[{dec_state, w[3:0]}]) opts.push_back(w[3:0]);
      c.win = opts[$urandom_range(0, opts.size() - 1)];
    end
    return c;
  endfunction

  task automatic send_cmd(input cmd_item_t c, input bit typed, input sym_res_t tres);
    int gap;
    int n;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = c.op;
    in_tdata = {c.win, c.syms, c.cnt, c.used, c.nxt, c.idx};
    do @(posedge clk); while (!in_tready);
    n = predict(c);
    if (typed) sym_fifo.push_back(tres);
    else for (int k = 0; k < n; k++) sym_fifo.push_back(step_res[k]);
  endtask

  // drain outstanding symbols, then let queued writes and restarts retire
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    burst_left = 0;
    while (sym_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [23:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    msg_len = val;
  endtask

  always @(negedge clk) begin
    if (rdy_cnt == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_cnt = $urandom_range(20, 80);
      rdy_pat = $urandom | 32'h1;
    end else begin
      rdy_cnt--;
    end
    case (rdy_mode)
      0: out_tready = 1'b1;
      1: begin
        out_tready = rdy_pat[0];
        rdy_pat = {rdy_pat[0], rdy_pat[31:1]};
      end
      2: out_tready = ($urandom_range(0, 3) != 0);
      default: out_tready = 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    sym_res_t got;
    sym_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{sym: out_tdata[7:0], valid: out_tuser[0], last: out_tlast,
              used: out_tdata[10:8], done: out_tdata[11]};
      if (sym_fifo.size() == 0) begin
        $error("unexpected transaction: symbol %0h valid %0b", got.sym, got.valid);
        fail_cnt++;
      end else begin
        want = sym_fifo.pop_front();
        if (got.sym !== want.sym) begin
          $error("symbol: expected %0h, got %0h", want.sym, got.sym);
          fail_cnt++;
        end
        if (got.valid !== want.valid) begin
          $error("symbol_valid: expected %0b, got %0b", want.valid, got.valid);
          fail_cnt++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, got.last);
          fail_cnt++;
        end
        if (got.used !== want.used) begin
          $error("bits_consumed: expected %0d, got %0d", want.used, got.used);
          fail_cnt++;
        end
        if (got.done !== want.done) begin
          $error("done_res: expected %0b, got %0b", want.done, got.done);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL huffman_lookahead_fsm_decoder");
    $finish;
  end

  initial begin
    cmd_item_t c;
    int        made;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    dir_cfg(24'd0);
    // state 511: saturated counts on window 15, an empty entry on window 0
    dir_cmd(OP_WRITE, 13'd8191, 9'd0, 3'd7, 3'd7, 32'h44332211, 4'hF);
    dir_cmd(OP_WRITE, 13'd8176, 9'd0, 3'd0, 3'd0, 32'hDEADBEEF, 4'h0);
    dir_cmd(OP_WRITE, 13'd0, 9'd0, 3'd1, 3'd1, 32'h000000A5, 4'h0);
    dir_cmd(OP_WRITE, 13'd15, 9'd511, 3'd4, 3'd4, 32'hFFFFFFFF, 4'hF);
    dir_cmd(OP_WRITE, 13'd8, 9'd0, 3'd2, 3'd2, 32'h00007F80, 4'h0);
    dir_done(4'hF);
    dir_cmd(OP_UNUSED, 13'h1FFF, 9'h1FF, 3'd7, 3'd7, 32'hFFFFFFFF, 4'hF);
    dir_cfg(24'd10);
    dir_cmd(OP_DECODE, 13'h1FFF, 9'h1FF, 3'd7, 3'd7, 32'hFFFFFFFF, 4'hF);
    dir_cmd(OP_DECODE, 13'd0, 9'd0, 3'd0, 3'd0, 32'h0, 4'h0);
    dir_cmd(OP_DECODE, 13'd0, 9'd0, 3'd0, 3'd0, 32'h0, 4'hF);
    // message ends inside this entry
    dir_cmd(OP_DECODE, 13'd0, 9'd0, 3'd0, 3'd0, 32'h0, 4'hF);
    dir_done(4'h8);
    dir_cmd(OP_RESTART, 13'h1FFF, 9'h1FF, 3'd7, 3'd7, 32'hFFFFFFFF, 4'hF);
    dir_cmd(OP_DECODE, 13'd0, 9'd0, 3'd0, 3'd0, 32'h0, 4'h0);
    dir_cmd(OP_DECODE, 13'd0, 9'd0, 3'd0, 3'd0, 32'h0, 4'h8);
    dir_cmd(OP_UNUSED, 13'd0, 9'd0, 3'd0, 3'd0, 32'h0, 4'h0);
    dir_cfg(24'hFFFFFF);
    dir_cmd(OP_RESTART, 13'd0, 9'd0, 3'd0, 3'd0, 32'h0, 4'h0);
    dir_cmd(OP_DECODE, 13'd0, 9'd0, 3'd0, 3'd0, 32'h0, 4'hF);
    dir_cmd(OP_DECODE, 13'd0, 9'd0, 3'd0, 3'd0, 32'h0, 4'hF);
    dir_cmd(OP_DECODE, 13'd0, 9'd0, 3'd0, 3'd0, 32'h0, 4'h0);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        settle();
        cfg_write(dir_tab[i].cfg_val);
      end else begin
        send_cmd(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    for (int p = 0; p < 5; p++) begin
      settle();
      case (p)
        0: cfg_write(24'($urandom_range(1, 12)));
        1: cfg_write(24'($urandom_range(30, 200)));
        2: cfg_write(24'hFFFFFF);
        3: cfg_write(24'($urandom_range(0, 3)));
        default: cfg_write(24'($urandom_range(1, 60)));
      endcase
      made = 0;
      while (made < PHASE_ITEMS) begin
        c = gen_item();
        if (c.op != OP_UNUSED) made++;
        send_cmd(c, 1'b0, DONE_RES);
      end
    end

    settle();
    if (fail_cnt == 0) begin
      $display("PASS huffman_lookahead_fsm_decoder");
    end else begin
      $display("FAIL huffman_lookahead_fsm_decoder");
    end
    $finish;
  end

endmodule
